@@ rtl/bleenc_pkg.sv @@
// ----------------------------------------------------------------------------
// BLE advertising encoder package
// Shared constants, types and bit-level functions for the CRC-24 and
// whitening datapath.
// ----------------------------------------------------------------------------
package bleenc_pkg;

  localparam int unsigned CrcW  = 24;
  localparam int unsigned ByteW = 8;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 24;
  localparam int unsigned TailW = 2;

  localparam logic [CrcW-1:0]  CrcTaps   = 24'h00065B;
  localparam logic [ByteW-1:0] LfsrTaps  = 8'h11;
  localparam logic [ByteW-1:0] SeedReset = 8'd166;
  localparam logic [CrcW-1:0]  CrcReset  = 24'h555555;

  // Three CRC bytes follow the last payload byte.
  localparam logic [TailW-1:0] TailCrcBytes = 2'd3;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgWhitenSeed = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgCrcInit    = 1'b1;

  // Result of coding one byte.
  typedef struct packed {
    logic [CrcW-1:0]  crc;
    logic [ByteW-1:0] lfsr;
    logic [ByteW-1:0] coded;
  } step_t;

  // Whitening result: next LFSR state and whitened byte.
  typedef struct packed {
    logic [ByteW-1:0] lfsr;
    logic [ByteW-1:0] data;
  } whiten_t;

  function automatic logic [ByteW-1:0] rev8(input logic [ByteW-1:0] b);
    logic [ByteW-1:0] r;
    for (int i = 0; i < ByteW; i++) begin
      r[i] = b[ByteW-1-i];
    end
    return r;
  endfunction

  // CRC-24 update, data fed least significant bit first.
  function automatic logic [CrcW-1:0] crc_byte(input logic [CrcW-1:0] crc,
                                               input logic [ByteW-1:0] b);
    logic [CrcW-1:0] c;
    logic            top;
    c = crc;
    for (int i = 0; i < ByteW; i++) begin
      top = c[CrcW-1];
      c   = {c[CrcW-2:0], 1'b0};
      if (top != b[i]) begin
        c = c ^ CrcTaps;
      end
    end
    return c;
  endfunction

  // Whitening, one LFSR step per bit starting at the byte's LSB.
  function automatic whiten_t whiten(input logic [ByteW-1:0] lfsr,
                                     input logic [ByteW-1:0] b);
    whiten_t w;
    w.lfsr = lfsr;
    w.data = b;
    for (int i = 0; i < ByteW; i++) begin
      if (w.lfsr[ByteW-1]) begin
        w.lfsr    = w.lfsr ^ LfsrTaps;
        w.data[i] = ~w.data[i];
      end
      w.lfsr = {w.lfsr[ByteW-2:0], 1'b0};
    end
    return w;
  endfunction

endpackage

@@ rtl/bleenc_in_if.sv @@
// ----------------------------------------------------------------------------
// BLE advertising encoder input channel
// Valid/ready channel that carries one header or payload byte per transfer.
// ----------------------------------------------------------------------------
interface bleenc_in_if;
  logic                        valid;
  logic                        ready;
  logic [bleenc_pkg::ByteW-1:0] data_byte;
  logic                        end_of_payload;

  modport source (output valid, output data_byte, output end_of_payload, input ready);
  modport sink   (input valid, input data_byte, input end_of_payload, output ready);
endinterface

@@ rtl/bleenc_out_if.sv @@
// ----------------------------------------------------------------------------
// BLE advertising encoder output channel
// Valid/ready channel that carries one coded byte per transfer.
// ----------------------------------------------------------------------------
interface bleenc_out_if;
  logic                        valid;
  logic                        ready;
  logic [bleenc_pkg::ByteW-1:0] coded_byte;
  logic                        packet_done;

  modport source (output valid, output coded_byte, output packet_done, input ready);
  modport sink   (input valid, input coded_byte, input packet_done, output ready);
endinterface

@@ rtl/bleenc_byte_coder.sv @@
// ----------------------------------------------------------------------------
// BLE advertising encoder byte coder
// Combinational CRC update and whitening for one payload byte, or the
// coding of the next CRC byte during the packet tail.
// ----------------------------------------------------------------------------
module bleenc_byte_coder (
  input  logic [bleenc_pkg::CrcW-1:0]  crc_i,
  input  logic [bleenc_pkg::ByteW-1:0] lfsr_i,
  input  logic [bleenc_pkg::ByteW-1:0] byte_i,
  input  logic                         tail_i,
  output bleenc_pkg::step_t            step_o
);

  bleenc_pkg::whiten_t w_data;
  bleenc_pkg::whiten_t w_crc;

  // Payload bytes are whitened as is; CRC bytes are whitened bit-reversed.
  assign w_data = bleenc_pkg::whiten(lfsr_i, byte_i);
  assign w_crc  = bleenc_pkg::whiten(lfsr_i,
                    bleenc_pkg::rev8(crc_i[bleenc_pkg::CrcW-1 -: bleenc_pkg::ByteW]));

  // Select between payload coding and CRC tail coding. Both leave the
  // block bit-reversed for the radio.
  always_comb begin
    if (tail_i) begin
      step_o.crc   = {crc_i[bleenc_pkg::CrcW-bleenc_pkg::ByteW-1:0],
                      {bleenc_pkg::ByteW{1'b0}}};
      step_o.lfsr  = w_crc.lfsr;
      step_o.coded = bleenc_pkg::rev8(w_crc.data);
    end else begin
      step_o.crc   = bleenc_pkg::crc_byte(crc_i, byte_i);
      step_o.lfsr  = w_data.lfsr;
      step_o.coded = bleenc_pkg::rev8(w_data.data);
    end
  end

endmodule

@@ rtl/ble_adv_packet_encoder.sv @@
// ----------------------------------------------------------------------------
// BLE advertising packet encoder
// CRC-24 generation and data whitening for BLE advertising packets.
// ----------------------------------------------------------------------------
// The block takes one header or payload byte per cycle and returns one coded
// byte per cycle while the output is not stalled, through a single output
// register, so bytes stream back to back. The byte marked end_of_payload is
// followed by the three CRC bytes, most significant first; these take three
// more output transfers, during which the input is held off. The last CRC
// byte carries packet_done. The CRC and the whitening LFSR are reloaded from
// crc_init and whiten_seed at the first byte of every packet; writes to those
// registers take effect at the next packet start.
module ble_adv_packet_encoder (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  bleenc_in_if.sink                       in_ch,
  bleenc_out_if.source                    out_ch,
  input  logic                            cfg_we_i,
  input  logic [bleenc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bleenc_pkg::CfgDataW-1:0] cfg_wdata_i
);

  logic [bleenc_pkg::ByteW-1:0] seed_q;
  logic [bleenc_pkg::CrcW-1:0]  crc_init_q;
  logic [bleenc_pkg::CrcW-1:0]  crc_q, crc_d;
  logic [bleenc_pkg::ByteW-1:0] lfsr_q, lfsr_d;
  logic                         mid_q, mid_d;
  logic [bleenc_pkg::TailW-1:0] tail_q, tail_d;
  logic                         out_valid_q, out_valid_d;
  logic [bleenc_pkg::ByteW-1:0] out_byte_q, out_byte_d;
  logic                         out_done_q, out_done_d;

  logic                         load_ok;
  logic                         in_fire;
  logic                         in_tail;
  logic [bleenc_pkg::CrcW-1:0]  crc_cur;
  logic [bleenc_pkg::ByteW-1:0] lfsr_cur;
  bleenc_pkg::step_t            step;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q     <= bleenc_pkg::SeedReset;
      crc_init_q <= bleenc_pkg::CrcReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bleenc_pkg::CfgWhitenSeed: seed_q     <= cfg_wdata_i[bleenc_pkg::ByteW-1:0];
        bleenc_pkg::CfgCrcInit:    crc_init_q <= cfg_wdata_i[bleenc_pkg::CrcW-1:0];
        default: ;
      endcase
    end
  end

  // The output register can take a new byte when empty or being drained.
  assign load_ok     = !out_valid_q || out_ch.ready;
  assign in_tail     = (tail_q != '0);
  assign in_ch.ready = load_ok && !in_tail;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // Packet start loads the presets.
  assign crc_cur  = mid_q ? crc_q  : crc_init_q;
  assign lfsr_cur = mid_q ? lfsr_q : seed_q;

  bleenc_byte_coder u_coder (
    .crc_i  (in_tail ? crc_q : crc_cur),
    .lfsr_i (in_tail ? lfsr_q : lfsr_cur),
    .byte_i (in_ch.data_byte),
    .tail_i (in_tail),
    .step_o (step)
  );

  // Next-state logic for the datapath and the output register.
  always_comb begin
    crc_d       = crc_q;
    lfsr_d      = lfsr_q;
    mid_d       = mid_q;
    tail_d      = tail_q;
    out_valid_d = out_valid_q && !out_ch.ready;
    out_byte_d  = out_byte_q;
    out_done_d  = out_done_q;
    if (in_tail && load_ok) begin
      crc_d       = step.crc;
      lfsr_d      = step.lfsr;
      tail_d      = tail_q - bleenc_pkg::TailW'(1);
      out_valid_d = 1'b1;
      out_byte_d  = step.coded;
      out_done_d  = (tail_q == bleenc_pkg::TailW'(1));
    end else if (in_fire) begin
      crc_d       = step.crc;
      lfsr_d      = step.lfsr;
      mid_d       = !in_ch.end_of_payload;
      tail_d      = in_ch.end_of_payload ? bleenc_pkg::TailCrcBytes : '0;
      out_valid_d = 1'b1;
      out_byte_d  = step.coded;
      out_done_d  = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_q       <= 1'b0;
      tail_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mid_q       <= mid_d;
      tail_q      <= tail_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath and payload registers.
  always_ff @(posedge clk_i) begin
    crc_q      <= crc_d;
    lfsr_q     <= lfsr_d;
    out_byte_q <= out_byte_d;
    out_done_q <= out_done_d;
  end

  assign out_ch.valid       = out_valid_q;
  assign out_ch.coded_byte  = out_byte_q;
  assign out_ch.packet_done = out_done_q;

  // A last payload byte starts a three-byte CRC tail.
  a_tail_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_ch.end_of_payload |=> tail_q == bleenc_pkg::TailCrcBytes && !mid_q)
    else $error("CRC tail not started after last payload byte");

  // packet_done only shows once the tail is finished and the packet closed.
  a_done_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_done_q |-> tail_q == '0 && !mid_q)
    else $error("packet_done shown before end of packet");

  // During the tail the output register is always occupied.
  a_tail_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_q != '0 |-> out_valid_q)
    else $error("CRC tail pending with empty output register");

endmodule
